### hdl/pnc_pkg.sv
// Shared types and constants of the palette nearest-colour search.
// Holds the word formats, controller/datapath command and status structs,
// the colour weights and the sRGB-to-linear lookup built at elaboration.
`timescale 1ns / 1ps
`default_nettype none

package pnc_pkg;

  // Input word: load or query, slot, and sRGB colour
  typedef struct packed {
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_data_t;

  // Result word of one query
  typedef struct packed {
    logic [7:0]  best_index;
    logic [31:0] min_distance;
    logic        palette_empty;
  } out_data_t;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_entry;   // write the input colour into the palette
    logic start_query;  // capture pixel, clear best and scan counter
    logic issue;        // read the next palette entry into the pipeline
    logic publish;      // move the best match into the output register
  } pnc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;   // no entry to compare
    logic issue_last;   // current read is the last active entry
    logic pipe_empty;   // no entry still in flight
  } pnc_sts_t;

  // Channel weights 0.299, 0.587, 0.114 in Q0.16
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef logic [15:0] lin_table_t [0:255];

  // Build the sRGB code to Q0.16 linear table; elaboration only
  function automatic lin_table_t build_lin_table();
    lin_table_t tab;
    logic [63:0] t, s, lo, hi, mid, v, y2, y4, p5;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        v = (64'(c) * 64'd1310700 + 64'd32946) / 64'd65892;
      end else begin
        t  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        s  = (t * t) >> 30;
        lo = 64'd0;
        hi = Q30_ONE;
        // largest y with y^5 <= s, truncating Q30 products
        for (int k = 0; k < 40; k++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            y2  = (mid * mid) >> 30;
            y4  = (y2 * y2) >> 30;
            p5  = (y4 * mid) >> 30;
            if (p5 <= s) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        v = (s * lo) >> 30;
        v = (v * 64'd65535 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd65535) begin
          v = 64'd65535;
        end
      end
      tab[c] = v[15:0];
    end
    return tab;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

### hdl/palette_nearest_color.sv
// Top level of the palette nearest-colour search.
// Joins pnc_ctrl and pnc_dp; types and constants from pnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette colour by weighted squared distance in linear light.
// A load word (req_type 0) converts its sRGB colour and writes palette slot
// entry_index, giving no result; slots at or above PALETTE_DEPTH are
// dropped. A query word (req_type 1) scans entries 0 .. n-1, with n the
// configured count capped at PALETTE_DEPTH and 256, and returns the first
// index with the smallest distance. One query occupies the block while the
// palette memory yields one entry per cycle and a four-stage distance
// pipeline drains at the end. With n zero the query answers with index 0,
// distance all ones and palette_empty set. The palette has no reset: every
// slot a query reaches must have been loaded first. The result sits in an
// output register, so a new word is taken while the previous result waits.
// Write cfg_data only while the block is idle.
module palette_nearest_color #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pnc_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pnc_pkg::out_data_t      out_data
);
  import pnc_pkg::*;

  pnc_cmd_t cmd;
  pnc_sts_t sts;
  logic     cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  pnc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_data.req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  pnc_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // An empty-palette result carries index 0 and saturated distance
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.palette_empty) |->
      (out_data.best_index == 8'd0 && out_data.min_distance == 32'hFFFF_FFFF))
    else $error("empty result with wrong index or distance");

  // No entry may be in flight while a new word can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> sts.pipe_empty)
    else $error("distance pipeline busy while accepting words");

  // The best match is handed off only after the pipeline has drained
  a_publish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> sts.pipe_empty)
    else $error("result published with entries in flight");

  // A published result is presented in the following cycle
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid)
    else $error("published result not presented");

endmodule

`default_nettype wire

### hdl/pnc_ctrl.sv
// Controller of the palette nearest-colour search.
// Sequences loads, palette scans and result hand-off; uses pnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_req_type,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pnc_pkg::pnc_cmd_t     cmd,
  input  wire pnc_pkg::pnc_sts_t sts
);
  import pnc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ISSUE   = 4'b0010,
    ST_DRAIN   = 4'b0100,
    ST_PUBLISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load_entry = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            state_nxt = sts.count_zero ? ST_PUBLISH : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/pnc_dp.sv
// Datapath of the palette nearest-colour search.
// Palette memory, linear conversion, distance pipeline and best-match
// tracking, driven by pnc_ctrl commands; uses pnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnc_dp #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_fire,
  input  wire logic [8:0]         cfg_data,
  input  wire pnc_pkg::in_data_t  in_data,
  input  wire pnc_pkg::pnc_cmd_t  cmd,
  output pnc_pkg::pnc_sts_t       sts,
  output pnc_pkg::out_data_t      out_data
);
  import pnc_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] COUNT_LIMIT =
    9'((PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256);

  // Palette count register
  logic [8:0] count_r;
  logic [8:0] n_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 9'd0;
    end else if (cfg_fire) begin
      count_r <= cfg_data;
    end
  end

  assign n_lim = (count_r > COUNT_LIMIT) ? COUNT_LIMIT : count_r;

  // Convert the incoming colour to linear light
  logic [47:0] in_lin;
  assign in_lin = {LIN_TABLE[in_data.red], LIN_TABLE[in_data.green],
                   LIN_TABLE[in_data.blue]};

  // Palette memory: one write port, one registered read port
  logic [47:0]   mem [PALETTE_DEPTH];
  logic [31:0]   wr_ext, rd_ext;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  logic [47:0]   rd_data_r;
  logic [8:0]    scan_cnt_r;

  assign wr_ext  = 32'(in_data.entry_index);
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_en   = cmd.load_entry && (wr_ext < 32'(PALETTE_DEPTH));
  assign rd_ext  = 32'(scan_cnt_r);
  assign rd_addr = rd_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_lin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Scan counter and captured pixel
  logic [47:0] px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= 9'd0;
    end else if (cmd.start_query) begin
      scan_cnt_r <= 9'd0;
    end else if (cmd.issue) begin
      scan_cnt_r <= scan_cnt_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      px_r <= in_lin;
    end
  end

  // Pipeline valid flags and entry index tags
  logic       v1_r, v2_r, v3_r, v4_r;
  logic [7:0] idx1_r, idx2_r, idx3_r, idx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= scan_cnt_r[7:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
  end

  // Stage 1: absolute channel differences, squared
  logic [15:0] d_red, d_green, d_blue;
  logic [31:0] sq_red_r, sq_green_r, sq_blue_r;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign d_red   = abs_diff(px_r[47:32], rd_data_r[47:32]);
  assign d_green = abs_diff(px_r[31:16], rd_data_r[31:16]);
  assign d_blue  = abs_diff(px_r[15:0],  rd_data_r[15:0]);

  always_ff @(posedge clk) begin
    sq_red_r   <= 32'(d_red) * 32'(d_red);
    sq_green_r <= 32'(d_green) * 32'(d_green);
    sq_blue_r  <= 32'(d_blue) * 32'(d_blue);
  end

  // Stage 2: apply channel weights
  logic [47:0] p_red_r, p_green_r, p_blue_r;

  always_ff @(posedge clk) begin
    p_red_r   <= 48'(sq_red_r) * 48'(W_RED);
    p_green_r <= 48'(sq_green_r) * 48'(W_GREEN);
    p_blue_r  <= 48'(sq_blue_r) * 48'(W_BLUE);
  end

  // Stage 3: sum, scale down and saturate
  logic [49:0] sum;
  logic [31:0] dist_r;

  assign sum = 50'(p_red_r) + 50'(p_green_r) + 50'(p_blue_r);

  always_ff @(posedge clk) begin
    dist_r <= (sum[49:48] != 2'b00) ? 32'hFFFF_FFFF : sum[47:16];
  end

  // Stage 4: keep the first strictly smallest distance
  logic        found_r;
  logic [31:0] best_d_r;
  logic [7:0]  best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.start_query) begin
      found_r <= 1'b0;
    end else if (v4_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      best_d_r   <= 32'hFFFF_FFFF;
      best_idx_r <= 8'd0;
    end else if (v4_r && (!found_r || (dist_r < best_d_r))) begin
      best_d_r   <= dist_r;
      best_idx_r <= idx4_r;
    end
  end

  // Output word register
  out_data_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.best_index    <= best_idx_r;
      out_data_r.min_distance  <= best_d_r;
      out_data_r.palette_empty <= !found_r;
    end
  end

  assign out_data = out_data_r;

  // Status to the controller
  assign sts.count_zero = (n_lim == 9'd0);
  assign sts.issue_last = (scan_cnt_r == (n_lim - 9'd1));
  assign sts.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);

endmodule

`default_nettype wire

### test/tb_palette_nearest_color.sv
// Testbench for palette_nearest_color: loads palette entries, runs queries,
// and checks each result against a shadow palette and distance search.
// Depends on pnc_pkg for the word types and request codes.
`timescale 1ns / 1ps

module tb_palette_nearest_color;
  import pnc_pkg::*;

  localparam int DEPTH         = 256;
  localparam int TOTAL_ITEMS   = 1650;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 300;
  localparam int MAX_REPORTS   = 10;

  // Colour weights 0.299, 0.587, 0.114 in Q0.16
  localparam longint unsigned WEIGHT_R = 19595;
  localparam longint unsigned WEIGHT_G = 38470;
  localparam longint unsigned WEIGHT_B = 7471;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [8:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_data_t out_data;

  palette_nearest_color #(
    .PALETTE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the palette, in linear light and as the loaded sRGB codes
  logic [15:0] srgb_lut [0:255];
  logic [47:0] shadow_lin [0:DEPTH-1];
  logic [23:0] shadow_code [0:DEPTH-1];
  bit          loaded [0:DEPTH-1];
  logic [8:0]  shadow_count;

  out_data_t nearest_q [$];
  int        items_sent;
  int        mismatch_count;
  bit        source_stalls;
  bit        sink_stalls;

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // sRGB code to Q0.16 linear: straight segment at the bottom, power curve above
  function automatic logic [15:0] srgb_to_linear(longint unsigned code);
    longint unsigned t, s, lo, hi, mid, y;
    if (code <= 10) begin
      y = (code * 1310700 + 32946) / 65892;
    end else begin
      t  = ((code * 1000 + 14025) << 30) / 269025;
      s  = q30_mul(t, t);
      lo = 0;
      hi = 64'd1 << 30;
      // bisect for the fifth root of s, rounding down
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        y   = q30_mul(q30_mul(q30_mul(mid, mid), q30_mul(mid, mid)), mid);
        if (y <= s) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      y = q30_mul(s, lo);
      y = (y * 65535 + (64'd1 << 29)) >> 30;
      if (y > 65535) begin
        y = 65535;
      end
    end
    return y[15:0];
  endfunction

  function automatic longint unsigned channel_sq(logic [15:0] a, logic [15:0] b);
    longint unsigned d;
    if (a > b) begin
      d = a - b;
    end else begin
      d = b - a;
    end
    return d * d;
  endfunction

  // Scan the active entries and keep the first strictly smallest distance
  function automatic out_data_t predict_nearest(logic [23:0] code);
    logic [15:0]     pr, pg, pb;
    logic [47:0]     e;
    longint unsigned n, sum, d, best_d;
    int              best;
    bit              found;
    out_data_t       r;
    pr = srgb_lut[code[23:16]];
    pg = srgb_lut[code[15:8]];
    pb = srgb_lut[code[7:0]];
    n  = shadow_count;
    if (n > DEPTH) begin
      n = DEPTH;
    end
    if (n > 256) begin
      n = 256;
    end
    found  = 1'b0;
    best   = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      e   = shadow_lin[i];
      sum = WEIGHT_R * channel_sq(pr, e[47:32]) + WEIGHT_G * channel_sq(pg, e[31:16])
          + WEIGHT_B * channel_sq(pb, e[15:0]);
      d = sum >> 16;
      if (d > 64'hFFFF_FFFF) begin
        d = 64'hFFFF_FFFF;
      end
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best   = i;
      end
    end
    if (!found) begin
      r.best_index    = 8'd0;
      r.min_distance  = 32'hFFFF_FFFF;
      r.palette_empty = 1'b1;
    end else begin
      r.best_index    = best[7:0];
      r.min_distance  = best_d[31:0];
      r.palette_empty = 1'b0;
    end
    return r;
  endfunction

  // Update the shadow palette or queue the answer for an accepted word
  function automatic void apply_word(in_data_t w);
    logic [23:0] code;
    code = {w.red, w.green, w.blue};
    if (w.req_type == REQ_LOAD) begin
      if (w.entry_index < DEPTH) begin
        shadow_lin[w.entry_index]  = {srgb_lut[w.red], srgb_lut[w.green], srgb_lut[w.blue]};
        shadow_code[w.entry_index] = code;
        loaded[w.entry_index]      = 1'b1;
      end
    end else begin
      nearest_q.push_back(predict_nearest(code));
    end
  endfunction

  function automatic in_data_t make_word(logic req, logic [7:0] idx, logic [23:0] code);
    in_data_t w;
    w.req_type    = req;
    w.entry_index = idx;
    w.red         = code[23:16];
    w.green       = code[15:8];
    w.blue        = code[7:0];
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  // Bias towards the ends of the range and the linear segment
  function automatic logic [7:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 10));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] rand_colour();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  function automatic logic [8:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 9'($urandom_range(1, 16));
    end else if (r < 55) begin
      return 9'($urandom_range(17, 64));
    end else if (r < 62) begin
      return 9'd0;
    end else if (r < 70) begin
      return 9'($urandom_range(1, 2));
    end else if (r < 78) begin
      return 9'd255;
    end else if (r < 86) begin
      return 9'd256;
    end else if (r < 94) begin
      return 9'($urandom_range(257, 510));
    end
    return 9'd511;
  endfunction

  // Present one word after an optional gap and hold it until taken
  task automatic send_word(input in_data_t w);
    int gap;
    gap = 0;
    if (source_stalls && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(w);
    items_sent++;
  endtask

  // Stop sending and wait until every outstanding answer has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [8:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queries straight after reset see an empty palette
  task automatic test_empty_palette();
    send_word(make_word(REQ_QUERY, 8'h00, 24'h000000));
    send_word(make_word(REQ_QUERY, 8'hFF, 24'hFFFFFF));
  endtask

  // Black, white, the linear segment and the top slot
  task automatic test_extreme_colours();
    drain_results();
    cfg_write(9'd3);
    send_word(make_word(REQ_LOAD, 8'd0, 24'h000000));
    send_word(make_word(REQ_LOAD, 8'd1, 24'hFFFFFF));
    send_word(make_word(REQ_LOAD, 8'd2, {8'd10, 8'd11, 8'd255}));
    send_word(make_word(REQ_LOAD, 8'd255, 24'hFF0080));
    send_word(make_word(REQ_QUERY, 8'h5A, 24'hFFFFFF));
    send_word(make_word(REQ_QUERY, 8'hA5, 24'h000000));
    send_word(make_word(REQ_QUERY, 8'h00, 24'hFFFF00));
    send_word(make_word(REQ_QUERY, 8'hFF, {8'd5, 8'd128, 8'd200}));
  endtask

  // Duplicate entries: the lower index must win
  task automatic test_tie_break();
    send_word(make_word(REQ_LOAD, 8'd3, 24'hFFFFFF));
    send_word(make_word(REQ_LOAD, 8'd4, 24'h000000));
    drain_results();
    cfg_write(9'd5);
    send_word(make_word(REQ_QUERY, 8'd0, 24'hFFFFFF));
    send_word(make_word(REQ_QUERY, 8'd0, 24'h000000));
    send_word(make_word(REQ_QUERY, 8'd0, 24'h808080));
  endtask

  // Phases with a fresh count each; fill the active slots before any query
  task automatic test_random_traffic();
    int          forced_counts [4];
    int          phase, n_active, len, pick;
    logic [8:0]  count;
    logic [7:0]  slot;
    logic [23:0] colour;
    forced_counts[0] = 256;
    forced_counts[1] = 511;
    forced_counts[2] = 0;
    forced_counts[3] = 255;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase < 4) begin
        count = 9'(forced_counts[phase]);
      end else begin
        count = pick_count();
      end
      source_stalls = ($urandom_range(0, 4) != 0);
      sink_stalls   = ($urandom_range(0, 4) != 0);
      drain_results();
      cfg_write(count);
      n_active = (count > DEPTH) ? DEPTH : count;
      for (int i = 0; i < n_active; i++) begin
        if (!loaded[i]) begin
          slot = 8'(i);
          send_word(make_word(REQ_LOAD, slot, rand_colour()));
        end
      end
      len = $urandom_range(15, 50);
      for (int k = 0; k < len && items_sent < TOTAL_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          // reload a slot, sometimes with a colour already present
          if (n_active > 0 && $urandom_range(0, 3) == 0) begin
            colour = shadow_code[$urandom_range(0, n_active - 1)];
          end else begin
            colour = rand_colour();
          end
          send_word(make_word(REQ_LOAD, 8'($urandom_range(0, 255)), colour));
        end else begin
          colour = rand_colour();
          if (n_active > 0 && pick < 6) begin
            colour = shadow_code[$urandom_range(0, n_active - 1)];
          end
          if (n_active > 0 && pick == 6) begin
            colour = shadow_code[$urandom_range(0, n_active - 1)];
            colour = {nudge(colour[23:16]), nudge(colour[15:8]), nudge(colour[7:0])};
          end
          send_word(make_word(REQ_QUERY, 8'($urandom_range(0, 255)), colour));
        end
      end
      phase++;
    end
    drain_results();
  endtask

  // Result side: random stalls on out_ready
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = pick_gap();
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest queued answer
  always @(posedge clk) begin : result_check
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (nearest_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result: index %0d distance %0d empty %0b",
                   out_data.best_index, out_data.min_distance, out_data.palette_empty);
        end
        mismatch_count++;
      end else begin
        want = nearest_q.pop_front();
        if (out_data.best_index !== want.best_index ||
            out_data.min_distance !== want.min_distance ||
            out_data.palette_empty !== want.palette_empty) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: index %0d/%0d distance %0d/%0d empty %0b/%0b (exp/got)",
                     want.best_index, out_data.best_index,
                     want.min_distance, out_data.min_distance,
                     want.palette_empty, out_data.palette_empty);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    source_stalls  = 1'b1;
    sink_stalls    = 1'b1;
    items_sent     = 0;
    mismatch_count = 0;
    shadow_count   = '0;
    for (int c = 0; c < 256; c++) begin
      srgb_lut[c] = srgb_to_linear(c);
    end
    for (int i = 0; i < DEPTH; i++) begin
      loaded[i]      = 1'b0;
      shadow_lin[i]  = '0;
      shadow_code[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_palette();
    test_extreme_colours();
    test_tie_break();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && nearest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
